// ----- rtl/core/assert_macros.svh -----
// Assertion helpers shared by the allocator modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define ASSERT_RST(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("allocator assertion failed");

// Checked at every clock edge, reset included.
`define ASSERT_ALL(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("allocator assertion failed");

`endif

// ----- rtl/core/bpa_pkg.sv -----
package bpa_pkg;

    // Fixed field widths.
    localparam int FRAME_W = 52;
    localparam int PAGES_W = 10;
    localparam int WORD_W  = 64;
    localparam int BIT_W   = 6;

    // Result status codes.
    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_FULL     = 2'd1,
        STS_OUTSIDE  = 2'd2,
        STS_NOT_USED = 2'd3
    } status_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RANGE,
        ST_CHECK,
        ST_PUSH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    start;
        logic    row_clr;
        logic    row_inc;
        logic    row_load;
        logic    alloc_wr;
        logic    free_wr;
        logic    res_load;
        status_t res_status;
        logic    out_load;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic found;
        logic outside;
        logic bit_used;
    } dp_sts_t;

endpackage

// ----- rtl/core/bpa_datapath.sv -----
`include "assert_macros.svh"

module bpa_datapath import bpa_pkg::*; #(
    parameter int PAGE_COUNT = 512
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [FRAME_W-1:0] cfg_wr_data,
    input  logic [FRAME_W-1:0] in_frame,
    input  dp_cmd_t            cmd,
    output dp_sts_t            sts,
    output status_t            out_status,
    output logic [FRAME_W-1:0] out_frame,
    output logic [PAGES_W-1:0] out_pages
);

    localparam int WORDS = (PAGE_COUNT + WORD_W - 1) / WORD_W;
    localparam int ROW_W = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int IDX_W = ROW_W + BIT_W;
    localparam int CNT_W = $clog2(PAGE_COUNT + 1);

    // Lowest clear bit of a word; callers make sure one exists.
    function automatic logic [BIT_W-1:0] first_zero(input logic [WORD_W-1:0] w);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (!w[i]) begin
                idx = BIT_W'(i);
            end
        end
        return idx;
    endfunction

    logic [FRAME_W-1:0] base_reg;
    logic [FRAME_W-1:0] frame_reg;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [BIT_W-1:0]   bit_reg;
    logic [CNT_W-1:0]   count_reg;
    status_t            res_status_reg;
    logic [FRAME_W-1:0] res_frame_reg;
    status_t            out_status_reg;
    logic [FRAME_W-1:0] out_frame_reg;
    logic [PAGES_W-1:0] out_pages_reg;

    logic [WORD_W-1:0]  mem [WORDS];
    logic [WORD_W-1:0]  rdata_reg;
    logic               rvalid_reg;
    logic [WORDS-1:0]   row_valid_reg;

    logic [FRAME_W:0]   diff;
    logic [WORD_W-1:0]  page_mask;
    logic [WORD_W-1:0]  word;
    logic [WORD_W-1:0]  eff_word;
    logic [BIT_W-1:0]   zero_bit;
    logic [IDX_W-1:0]   alloc_idx;
    logic [FRAME_W-1:0] alloc_frame;
    logic               wr_en;
    logic [WORD_W-1:0]  wr_data;
    logic [CNT_W+PAGES_W-1:0] count_ext;

    // Offset of the frame to free from the region base, with borrow on top.
    assign diff = {1'b0, frame_reg} - {1'b0, base_reg};

    // Bits past the end of the region count as used.
    always_comb begin
        for (int b = 0; b < WORD_W; b++) begin
            page_mask[b] = ((int'(row_reg) * WORD_W) + b) < PAGE_COUNT;
        end
    end

    // A row never written reads as all free.
    assign word      = rvalid_reg ? rdata_reg : '0;
    assign eff_word  = word | ~page_mask;
    assign zero_bit  = first_zero(eff_word);
    assign alloc_idx = {row_reg, zero_bit};
    assign alloc_frame = base_reg + FRAME_W'(alloc_idx);

    // Status toward the controller.
    assign sts.full     = (count_reg == CNT_W'(PAGE_COUNT));
    assign sts.found    = ~&eff_word;
    assign sts.outside  = diff[FRAME_W] || (diff[FRAME_W-1:0] >= FRAME_W'(PAGE_COUNT));
    assign sts.bit_used = word[bit_reg];

    // Row pointer for the bitmap read port.
    always_comb begin
        row_next = row_reg;
        if (cmd.row_clr) begin
            row_next = '0;
        end else if (cmd.row_inc) begin
            row_next = row_reg + ROW_W'(1);
        end else if (cmd.row_load) begin
            row_next = diff[IDX_W-1:BIT_W];
        end
    end

    // Read-modify-write data for the current row.
    always_comb begin
        wr_en   = cmd.alloc_wr || cmd.free_wr;
        wr_data = word & ~(WORD_W'(1) << bit_reg);
        if (cmd.alloc_wr) begin
            wr_data = word | (WORD_W'(1) << zero_bit);
        end
    end

    // Bitmap memory, one 64-page word per row, registered read.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[row_reg] <= wr_data;
        end
        rdata_reg <= mem[row_next];
    end

    // Row valid bits stand in for clearing the memory at reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
            rvalid_reg    <= 1'b0;
        end else begin
            if (wr_en) begin
                row_valid_reg[row_reg] <= 1'b1;
            end
            rvalid_reg <= row_valid_reg[row_next];
        end
    end

    // Base register, count and row pointer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg  <= '0;
            count_reg <= '0;
            row_reg   <= '0;
        end else begin
            if (cfg_wr_en) begin
                base_reg <= cfg_wr_data;
            end
            if (cmd.alloc_wr) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (cmd.free_wr) begin
                count_reg <= count_reg - CNT_W'(1);
            end
            row_reg <= row_next;
        end
    end

    // Payload registers: input frame, pending result, output beat.
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            frame_reg <= in_frame;
        end
        if (cmd.row_load) begin
            bit_reg <= diff[BIT_W-1:0];
        end
        if (cmd.res_load) begin
            res_status_reg <= cmd.res_status;
            res_frame_reg  <= cmd.alloc_wr ? alloc_frame : '0;
        end
        if (cmd.out_load) begin
            out_status_reg <= res_status_reg;
            out_frame_reg  <= res_frame_reg;
            out_pages_reg  <= count_ext[PAGES_W-1:0];
        end
    end

    assign count_ext  = {{PAGES_W{1'b0}}, count_reg};
    assign out_status = out_status_reg;
    assign out_frame  = out_frame_reg;
    assign out_pages  = out_pages_reg;

    // The count can never pass the region size.
    `ASSERT_RST(a_count_bound, aclk, aresetn, count_reg <= CNT_W'(PAGE_COUNT))
    // An allocation claims a page inside the region that was free.
    `ASSERT_RST(a_alloc_free, aclk, aresetn, cmd.alloc_wr |-> !eff_word[zero_bit])
    // A free only clears a bit that was set.
    `ASSERT_RST(a_free_set, aclk, aresetn, cmd.free_wr |-> word[bit_reg])

endmodule

// ----- rtl/core/bpa_ctrl.sv -----
`include "assert_macros.svh"

module bpa_ctrl import bpa_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    input  logic    in_cmd,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    state_next = in_cmd ? ST_RANGE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (sts.full || sts.found) begin
                    state_next = ST_PUSH;
                end
            end
            ST_RANGE: begin
                state_next = sts.outside ? ST_PUSH : ST_CHECK;
            end
            ST_CHECK: begin
                state_next = ST_PUSH;
            end
            ST_PUSH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath commands.
    always_comb begin
        cmd = '0;
        cmd.res_status = STS_OK;
        case (state_reg)
            ST_IDLE: begin
                cmd.start   = in_valid;
                cmd.row_clr = in_valid && !in_cmd;
            end
            ST_SCAN: begin
                if (sts.full) begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = STS_FULL;
                end else if (sts.found) begin
                    cmd.alloc_wr = 1'b1;
                    cmd.res_load = 1'b1;
                end else begin
                    cmd.row_inc = 1'b1;
                end
            end
            ST_RANGE: begin
                if (sts.outside) begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = STS_OUTSIDE;
                end else begin
                    cmd.row_load = 1'b1;
                end
            end
            ST_CHECK: begin
                cmd.res_load = 1'b1;
                if (sts.bit_used) begin
                    cmd.free_wr = 1'b1;
                end else begin
                    cmd.res_status = STS_NOT_USED;
                end
            end
            ST_PUSH: begin
                cmd.out_load = out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    // Output beat valid flag.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    // Reset always lands in idle with no beat on offer.
    `ASSERT_ALL(a_rst_idle, aclk, !aresetn |=> (state_reg == ST_IDLE && !out_valid_reg))
    // A finished result waits while the output register is still occupied.
    `ASSERT_RST(a_push_wait, aclk, aresetn, state_reg == ST_PUSH && !out_free |=> $stable(state_reg))

endmodule

// ----- rtl/core/bitmap_page_allocator.sv -----
// Sequence: a free passes the range check and, when the frame lies inside the region, the
// bit check before its result beat is loaded; an allocate scans the bitmap one 64-page word
// per cycle until it finds a free page, or stops at once when full. A new command is accepted
// only in idle, once the result of the last one has been loaded into the output register.
// Reset: synchronous active low; every page free, count zero, base frame zero, no
// clearing pass since per-row valid bits mark unwritten bitmap words as free.
module bitmap_page_allocator import bpa_pkg::*; #(
    parameter int PAGE_COUNT = 512
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Configuration: base frame of the region.
    input  logic                 cfg_wr_en,
    input  logic [FRAME_W-1:0]   cfg_wr_data,
    // Command channel.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [55:0]          s_tdata,   // [51:0] frame_in, [55:52] zero
    input  logic [0:0]           s_tuser,   // [0] cmd
    // Result channel.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [63:0]          m_tdata,   // [51:0] frame_out, [61:52] pages_in_use, [63:62] zero
    output logic [1:0]           m_tuser    // [1:0] status
);

    dp_cmd_t            cmd;
    dp_sts_t            sts;
    status_t            out_status;
    logic [FRAME_W-1:0] out_frame;
    logic [PAGES_W-1:0] out_pages;

    bpa_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_cmd    (s_tuser[0]),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    bpa_datapath #(
        .PAGE_COUNT (PAGE_COUNT)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_frame    (s_tdata[FRAME_W-1:0]),
        .cmd         (cmd),
        .sts         (sts),
        .out_status  (out_status),
        .out_frame   (out_frame),
        .out_pages   (out_pages)
    );

    // Pack the result beat.
    assign m_tdata = {2'b00, out_pages, out_frame};
    assign m_tuser = out_status;

endmodule
